>>> rtl/assert_macros.svh
// shared assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

>>> rtl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared constants of the one-wire bus master: register indexes, register
// widths and reset values, command codes.
// ----------------------------------------------------------------------------
package owm_pkg;

  // register index and data widths
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned LONG_REG_W  = 10;
  localparam int unsigned SHORT_REG_W = 8;
  // widest limit, covers every count width in range
  localparam int unsigned LIMIT_W     = 16;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [LONG_REG_W-1:0]  long_reg_t;
  typedef logic [SHORT_REG_W-1:0] short_reg_t;

  // register indexes
  localparam cfg_index_t REG_RESET_LOW      = 3'd0;
  localparam cfg_index_t REG_RELEASE_WAIT   = 3'd1;
  localparam cfg_index_t REG_PRES_START_LIM = 3'd2;
  localparam cfg_index_t REG_PRES_END_LIM   = 3'd3;
  localparam cfg_index_t REG_SHORT_LOW      = 3'd4;
  localparam cfg_index_t REG_LONG_LOW       = 3'd5;
  localparam cfg_index_t REG_SAMPLE_DELAY   = 3'd6;
  localparam cfg_index_t REG_READ_RECOVER   = 3'd7;

  // register reset values
  localparam long_reg_t  RST_RESET_LOW      = 10'd600;
  localparam short_reg_t RST_RELEASE_WAIT   = 8'd10;
  localparam long_reg_t  RST_PRES_START_LIM = 10'd200;
  localparam long_reg_t  RST_PRES_END_LIM   = 10'd240;
  localparam short_reg_t RST_SHORT_LOW      = 8'd2;
  localparam short_reg_t RST_LONG_LOW       = 8'd60;
  localparam short_reg_t RST_SAMPLE_DELAY   = 8'd12;
  localparam short_reg_t RST_READ_RECOVER   = 8'd50;

  // command codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

endpackage

>>> rtl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master sequencer: reset with presence detect, byte write and
// byte read, stepped by one tick per accepted input transaction.
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+-------------------------------
// in       | in        | in_valid / in_stall  | action, tx_byte, line_in
// out      | out       | out_valid / out_stall| drive_low, busy_res, done_res,
//          |           |                      | presence_ok, rx_byte
// cfg      | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one tick is taken per cycle unless in_stall holds it; its result sits in the
// output register on the next cycle.
// the next-state logic is one counter increment and one limit compare.
// in_stall is raised only while a result waits in the output register and the
// receiver stalls it.
// rst is synchronous, clears sequencer state and loads register defaults.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module one_wire_bus_master
  import owm_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [7:0]            tx_byte,
  input  logic                  line_in,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  drive_low,
  output logic                  busy_res,
  output logic                  done_res,
  output logic                  presence_ok,
  output logic [7:0]            rx_byte,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  // sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_RST_LOW    = 4'd1;
  localparam logic [3:0] PH_RST_WAIT   = 4'd2;
  localparam logic [3:0] PH_PRES_START = 4'd3;
  localparam logic [3:0] PH_PRES_END   = 4'd4;
  localparam logic [3:0] PH_WR_LOW     = 4'd5;
  localparam logic [3:0] PH_WR_HIGH    = 4'd6;
  localparam logic [3:0] PH_RD_LOW     = 4'd7;
  localparam logic [3:0] PH_RD_WAIT    = 4'd8;
  localparam logic [3:0] PH_RD_RECOVER = 4'd9;

  localparam logic [LIMIT_W-1:0] CNT_MAX =
    LIMIT_W'((32'd1 << COUNT_WIDTH) - 32'd1);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // configuration registers
  long_reg_t  reset_low_time;
  short_reg_t release_wait_time;
  long_reg_t  presence_start_limit;
  long_reg_t  presence_end_limit;
  short_reg_t short_low_time;
  short_reg_t long_low_time;
  short_reg_t sample_delay;
  short_reg_t read_recover_time;

  // sequencer state
  logic [3:0] phase;
  count_t     time_count;
  logic [2:0] bit_index;
  logic [7:0] shift_byte;
  logic       presence_flag;
  logic [7:0] rx_hold;

  logic [3:0] phase_next;
  count_t     time_count_next;
  logic [2:0] bit_index_next;
  logic [7:0] shift_byte_next;
  logic       presence_flag_next;
  logic [7:0] rx_hold_next;
  logic       drive_next;
  logic       done_next;

  logic in_accept;

  // zero counts as one, anything past the counter range is clamped
  function automatic count_t eff_limit(input long_reg_t v);
    logic [LIMIT_W-1:0] w;
    begin
      w = (v == '0) ? LIMIT_W'(1) : LIMIT_W'(v);
      if (w > CNT_MAX) begin
        w = CNT_MAX;
      end
      return w[COUNT_WIDTH-1:0];
    end
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = out_valid && out_stall;
  assign cfg_ready = 1'b1;

  // next state for one tick
  always_comb begin
    long_reg_t lim_raw;
    count_t    lim;
    count_t    tc_inc;
    logic      seg_end;

    phase_next         = phase;
    time_count_next    = time_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    rx_hold_next       = rx_hold;
    drive_next         = 1'b0;
    done_next          = 1'b0;

    // command start in idle
    if (phase == PH_IDLE && action != ACT_NONE) begin
      time_count_next = '0;
      bit_index_next  = '0;
      case (action)
        ACT_RESET: phase_next = PH_RST_LOW;
        ACT_WRITE: begin
          shift_byte_next = tx_byte;
          phase_next      = PH_WR_LOW;
        end
        default: begin
          shift_byte_next = '0;
          phase_next      = PH_RD_LOW;
        end
      endcase
    end

    // segment length of the current phase
    case (phase_next)
      PH_RST_LOW:    lim_raw = reset_low_time;
      PH_RST_WAIT:   lim_raw = LONG_REG_W'(release_wait_time);
      PH_PRES_START: lim_raw = presence_start_limit;
      PH_PRES_END:   lim_raw = presence_end_limit;
      PH_WR_LOW:     lim_raw = LONG_REG_W'(shift_byte_next[0] ? short_low_time
                                                             : long_low_time);
      PH_WR_HIGH:    lim_raw = LONG_REG_W'(shift_byte_next[0] ? long_low_time
                                                             : short_low_time);
      PH_RD_LOW:     lim_raw = LONG_REG_W'(short_low_time);
      PH_RD_WAIT:    lim_raw = LONG_REG_W'(sample_delay);
      PH_RD_RECOVER: lim_raw = LONG_REG_W'(read_recover_time);
      default:       lim_raw = LONG_REG_W'(1);
    endcase
    lim     = eff_limit(lim_raw);
    tc_inc  = time_count_next + count_t'(1);
    seg_end = (tc_inc >= lim);

    // phase actions
    unique case (phase_next)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        drive_next      = 1'b1;
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          phase_next = PH_RST_WAIT;
        end
      end
      PH_RST_WAIT: begin
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          phase_next = PH_PRES_START;
        end
      end
      PH_PRES_START: begin
        if (!line_in) begin
          phase_next      = PH_PRES_END;
          time_count_next = '0;
        end else if (seg_end) begin
          presence_flag_next = 1'b0;
          done_next          = 1'b1;
          phase_next         = PH_IDLE;
          time_count_next    = '0;
          bit_index_next     = '0;
        end else begin
          time_count_next = tc_inc;
        end
      end
      PH_PRES_END: begin
        if (line_in || seg_end) begin
          presence_flag_next = line_in;
          done_next          = 1'b1;
          phase_next         = PH_IDLE;
          time_count_next    = '0;
          bit_index_next     = '0;
        end else begin
          time_count_next = tc_inc;
        end
      end
      PH_WR_LOW: begin
        drive_next      = 1'b1;
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          phase_next = PH_WR_HIGH;
        end
      end
      PH_WR_HIGH: begin
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          shift_byte_next = {1'b0, shift_byte_next[7:1]};
          if (bit_index_next == 3'd7) begin
            done_next      = 1'b1;
            phase_next     = PH_IDLE;
            bit_index_next = '0;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive_next      = 1'b1;
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          phase_next = PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          phase_next = PH_RD_RECOVER;
        end
      end
      PH_RD_RECOVER: begin
        // sample on the first recovery tick
        if (time_count_next == '0) begin
          shift_byte_next = {line_in, shift_byte_next[7:1]};
        end
        time_count_next = seg_end ? '0 : tc_inc;
        if (seg_end) begin
          if (bit_index_next == 3'd7) begin
            rx_hold_next   = shift_byte_next;
            done_next      = 1'b1;
            phase_next     = PH_IDLE;
            bit_index_next = '0;
          end else begin
            bit_index_next = bit_index_next + 3'd1;
            phase_next     = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_next      = PH_IDLE;
        time_count_next = '0;
        bit_index_next  = '0;
      end
    endcase
  end

  // control state, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time       <= RST_RESET_LOW;
      release_wait_time    <= RST_RELEASE_WAIT;
      presence_start_limit <= RST_PRES_START_LIM;
      presence_end_limit   <= RST_PRES_END_LIM;
      short_low_time       <= RST_SHORT_LOW;
      long_low_time        <= RST_LONG_LOW;
      sample_delay         <= RST_SAMPLE_DELAY;
      read_recover_time    <= RST_READ_RECOVER;
      phase                <= PH_IDLE;
      time_count           <= '0;
      bit_index            <= '0;
      shift_byte           <= '0;
      presence_flag        <= 1'b0;
      rx_hold              <= '0;
      out_valid            <= 1'b0;
    end else begin
      // register write decode
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_RESET_LOW:      reset_low_time       <= cfg_data;
          REG_RELEASE_WAIT:   release_wait_time    <= cfg_data[SHORT_REG_W-1:0];
          REG_PRES_START_LIM: presence_start_limit <= cfg_data;
          REG_PRES_END_LIM:   presence_end_limit   <= cfg_data;
          REG_SHORT_LOW:      short_low_time       <= cfg_data[SHORT_REG_W-1:0];
          REG_LONG_LOW:       long_low_time        <= cfg_data[SHORT_REG_W-1:0];
          REG_SAMPLE_DELAY:   sample_delay         <= cfg_data[SHORT_REG_W-1:0];
          REG_READ_RECOVER:   read_recover_time    <= cfg_data[SHORT_REG_W-1:0];
          default: begin
          end
        endcase
      end
      // sequencer advance
      if (in_accept) begin
        phase         <= phase_next;
        time_count    <= time_count_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        presence_flag <= presence_flag_next;
        rx_hold       <= rx_hold_next;
      end
      // output register occupancy
      if (in_accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low   <= drive_next;
      busy_res    <= (phase_next != PH_IDLE);
      done_res    <= done_next;
      presence_ok <= presence_flag_next;
      rx_byte     <= rx_hold_next;
    end
  end

  // checks
  `ASSERT_SAME(a_done_not_busy, clk, rst, out_valid && done_res, !busy_res)
  `ASSERT_SAME(a_drive_while_busy, clk, rst, out_valid && drive_low, busy_res)
  `ASSERT_SAME(a_bit_idle_clear, clk, rst, bit_index != 3'd0, phase != PH_IDLE)
  `ASSERT_NEXT(a_accept_fills_out, clk, rst, in_valid && !in_stall, out_valid)

endmodule
